// File: rtl/dns_name_label_encoder_defines.svh
// Assertion macros shared by the checker of the DNS name label encoder.
// Depends on a clk and an arst_n signal in the scope that uses them.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DNLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DNLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dnle_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the DNS name label encoder.
// No dependencies; imported by dnle_front, dnle_cmdq, dnle_back and the top level.
package dnle_pkg;

	localparam int MAX_LABEL  = 63;
	localparam int CHAR_W     = 8;
	localparam int CNT_W      = 6;
	localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

	// Two label banks, each split into even and odd character RAMs
	localparam int BANKS      = 2;
	localparam int RAM_DEPTH  = 64;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int HALF_AW    = RAM_AW - 1;

	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	localparam int OUT_TDATA_W = 24;

	typedef enum logic {
		CMD_FLUSH,
		CMD_ERROR
	} cmd_kind_t;

	// Command from the front to the back
	typedef struct packed {
		cmd_kind_t          kind;
		logic [CNT_W-1:0]   cnt;
		logic               bank;
		logic               root;
	} cmd_t;

	// Character write into the label RAMs
	typedef struct packed {
		logic               we_even;
		logic               we_odd;
		logic [RAM_AW-1:0]  addr;
		logic [CHAR_W-1:0]  data;
	} ram_wr_t;

	// Back reports a finished label flush so its bank can be reused
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_done_t;

	typedef struct packed {
		logic [CHAR_W-1:0] first_byte;
		logic [CHAR_W-1:0] second_byte;
		logic              pair_valid;
		logic              run_last;
		logic              label_error;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_EMIT
	} bk_state_t;

endpackage

// File: rtl/dnle_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/dnle_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters, buffers labels into the RAM banks and
// issues flush and error commands. Depends on dnle_pkg.
module dnle_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // name_char[7:0]
	input  logic                   s_tlast,   // end_of_name
	input  logic                   q_full,
	output logic                   push,
	output dnle_pkg::cmd_t         cmd,
	output dnle_pkg::ram_wr_t      wr,
	input  dnle_pkg::bank_done_t   done
);
	import dnle_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             disc_q, disc_d;
	logic             bank_q, bank_d;
	logic [BANKS-1:0] busy_q, busy_d, busy_set;
	logic             accept;

	assign s_tready = !q_full && !busy_q[bank_q];
	assign accept   = s_tvalid && s_tready;

	// Classify the accepted item
	always_comb begin
		push     = 1'b0;
		cmd      = '0;
		wr       = '0;
		cnt_d    = cnt_q;
		disc_d   = disc_q;
		bank_d   = bank_q;
		busy_set = '0;
		if (accept) begin
			priority if (s_tlast) begin
				if (disc_q) begin
					disc_d = 1'b0;
					cnt_d  = '0;
				end else begin
					push      = 1'b1;
					cmd.kind  = CMD_FLUSH;
					cmd.cnt   = cnt_q;
					cmd.bank  = bank_q;
					cmd.root  = 1'b1;
					if (cnt_q != '0) begin
						busy_set[bank_q] = 1'b1;
						bank_d           = !bank_q;
					end
					cnt_d = '0;
				end
			end else if (disc_q) begin
				cnt_d = cnt_q;
			end else if (s_tdata == DOT_CHAR) begin
				if (cnt_q != '0) begin
					push             = 1'b1;
					cmd.kind         = CMD_FLUSH;
					cmd.cnt          = cnt_q;
					cmd.bank         = bank_q;
					cmd.root         = 1'b0;
					busy_set[bank_q] = 1'b1;
					bank_d           = !bank_q;
					cnt_d            = '0;
				end
			end else if (cnt_q >= CNT_W'(MAX_LABEL)) begin
				push     = 1'b1;
				cmd.kind = CMD_ERROR;
				cnt_d    = '0;
				disc_d   = 1'b1;
			end else begin
				wr.we_even = !cnt_q[0];
				wr.we_odd  = cnt_q[0];
				wr.addr    = {bank_q, cnt_q[CNT_W-1:1]};
				wr.data    = s_tdata;
				cnt_d      = cnt_q + CNT_W'(1);
			end
		end
	end

	// Mark banks busy on flush, free them when the back finishes
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			busy_d[b] = busy_set[b] |
				(busy_q[b] & !(done.valid && (done.bank == 1'(b))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			disc_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			cnt_q  <= cnt_d;
			disc_q <= disc_d;
			bank_q <= bank_d;
			busy_q <= busy_d;
		end
	end

endmodule

// File: rtl/dnle_cmdq.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back end.
// Depends on dnle_pkg.
module dnle_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dnle_pkg::cmd_t   din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output dnle_pkg::cmd_t   dout
);
	import dnle_pkg::*;

	cmd_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(Q_DEPTH));
	assign valid = (count_q != '0);
	assign dout  = entry_q[rptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/dnle_back.sv
`timescale 1ns / 1ps
// Back end: executes flush and error commands, reads the label RAMs and
// holds the output result register. Depends on dnle_pkg.
module dnle_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  dnle_pkg::cmd_t          q_cmd,
	output logic                    pop,
	output logic [dnle_pkg::RAM_AW-1:0] even_raddr,
	output logic [dnle_pkg::RAM_AW-1:0] odd_raddr,
	input  logic [dnle_pkg::CHAR_W-1:0] even_rdata,
	input  logic [dnle_pkg::CHAR_W-1:0] odd_rdata,
	output dnle_pkg::bank_done_t    done,
	output logic                    res_valid,
	output dnle_pkg::result_t       res,
	input  logic                    res_ready
);
	import dnle_pkg::*;

	bk_state_t         state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              bank_q;
	logic              root_q;
	logic [CNT_W-1:0]  pair_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic              direct;
	logic              latch;
	logic              load;
	result_t           res_d;
	result_t           pair_res;
	logic              pair_last;
	logic [CNT_W-1:0]  pair_m1;
	logic [CNT_W:0]    n_ext;
	logic [CNT_W:0]    total;
	logic [CNT_W:0]    two_j;

	assign out_free  = !out_valid_q || res_ready;
	assign direct    = (q_cmd.kind == CMD_ERROR) || (q_cmd.cnt == '0);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Read addresses follow the pair counter
	assign pair_m1    = pair_q - CNT_W'(1);
	assign even_raddr = {bank_q, pair_q[HALF_AW-1:0]};
	assign odd_raddr  = {bank_q, pair_m1[HALF_AW-1:0]};

	// Build the byte pair: length byte, characters, then optional root zero
	always_comb begin
		n_ext = {1'b0, cnt_q};
		total = n_ext + (CNT_W+1)'(1) + (CNT_W+1)'(root_q);
		two_j = {pair_q, 1'b0};
		pair_res = '0;
		if (pair_q == '0) begin
			pair_res.first_byte  = CHAR_W'(cnt_q);
			pair_res.second_byte = even_rdata;
		end else begin
			pair_res.first_byte  = (two_j <= n_ext) ? odd_rdata : '0;
			pair_res.second_byte = (two_j + (CNT_W+1)'(1) <= n_ext) ? even_rdata : '0;
		end
		pair_res.pair_valid  = (two_j + (CNT_W+1)'(1)) < total;
		pair_last            = (two_j + (CNT_W+1)'(2)) >= total;
		pair_res.run_last    = pair_last;
		pair_res.label_error = 1'b0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && !direct) begin
					state_d = BK_ISSUE;
				end
			end
			BK_ISSUE: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				// Read the next pair before emitting it
				if (out_free) begin
					state_d = pair_last ? BK_IDLE : BK_ISSUE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		pop   = 1'b0;
		latch = 1'b0;
		load  = 1'b0;
		res_d = '0;
		done  = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (direct) begin
						if (out_free) begin
							pop               = 1'b1;
							load              = 1'b1;
							res_d.run_last    = 1'b1;
							res_d.label_error = (q_cmd.kind == CMD_ERROR);
						end
					end else begin
						pop   = 1'b1;
						latch = 1'b1;
					end
				end
			end
			BK_ISSUE: begin
				load = 1'b0;
			end
			BK_EMIT: begin
				if (out_free) begin
					load       = 1'b1;
					res_d      = pair_res;
					done.valid = pair_last;
					done.bank  = bank_q;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Command context and pair counter
	always_ff @(posedge clk) begin
		if (latch) begin
			cnt_q  <= q_cmd.cnt;
			bank_q <= q_cmd.bank;
			root_q <= q_cmd.root;
			pair_q <= '0;
		end else if (load && (state_q == BK_EMIT)) begin
			pair_q <= pair_q + CNT_W'(1);
		end
		if (load) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/dns_name_label_encoder.sv
`timescale 1ns / 1ps
// DNS name label encoder: a dotted name arrives one character per transfer
// (s_tlast marks the end of the name) and leaves in wire form, a length byte
// per label followed by its characters and a closing root zero, two bytes per
// output transfer. Empty labels produce nothing; a label over 63 characters
// gives one transfer with m_tuser set and the rest of that name is dropped.
// The front takes one character per cycle while s_tready is high and writes it
// into one of two label banks; a dot or the end marker hands the bank to the
// back through a two-entry command queue. The back takes the command, then for
// each output pair registers a RAM read and then loads the output register.
// Error and root-only results are loaded straight from the command without a
// RAM read. The front holds s_tready low while the bank it would fill is still
// being drained or the command queue is full. Depends on dnle_pkg, dnle_front,
// dnle_cmdq, dnle_back and dnle_ram.
module dns_name_label_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // name_char[7:0]
	input  logic        s_tlast,   // end_of_name
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // first_byte[7:0], second_byte[15:8], pair_valid[16], zero
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // label_error
);
	import dnle_pkg::*;

	logic              q_full, q_push, q_pop, q_valid;
	cmd_t              q_din, q_dout;
	ram_wr_t           wr;
	bank_done_t        done;
	logic [RAM_AW-1:0] even_raddr, odd_raddr;
	logic [CHAR_W-1:0] even_rdata, odd_rdata;
	result_t           res;

	dnle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_din),
		.wr       (wr),
		.done     (done)
	);

	dnle_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	// Even-indexed label characters
	dnle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_even (
		.clk   (clk),
		.we    (wr.we_even),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (even_raddr),
		.rdata (even_rdata)
	);

	// Odd-indexed label characters
	dnle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (RAM_DEPTH)
	) u_ram_odd (
		.clk   (clk),
		.we    (wr.we_odd),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (odd_raddr),
		.rdata (odd_rdata)
	);

	dnle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_dout),
		.pop        (q_pop),
		.even_raddr (even_raddr),
		.odd_raddr  (odd_raddr),
		.even_rdata (even_rdata),
		.odd_rdata  (odd_rdata),
		.done       (done),
		.res_valid  (m_tvalid),
		.res        (res),
		.res_ready  (m_tready)
	);

	// Pack the result onto the master side
	assign m_tdata = {7'b0, res.pair_valid, res.second_byte, res.first_byte};
	assign m_tlast = res.run_last;
	assign m_tuser = res.label_error;

endmodule

// File: rtl/dnle_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the DNS name label encoder, bound to the top level.
// Depends on dns_name_label_encoder_defines.svh.
`include "dns_name_label_encoder_defines.svh"
module dnle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// Output stays valid until taken
	`DNLE_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

	// Stalled payload holds
	`DNLE_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "payload changed while stalled")

	// Error result is a lone, empty, last transfer
	`DNLE_ASSERT(a_err_shape, m_tvalid && m_tuser |-> m_tlast && (m_tdata == 24'd0), "malformed error result")

	// A single-byte result ends its run and carries no second byte
	`DNLE_ASSERT(a_single_last, m_tvalid && !m_tdata[16] |-> m_tlast && (m_tdata[15:8] == 8'd0), "single byte result not last")

	// No output during reset
	`DNLE_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> (m_tvalid !== 1'b1), "m_tvalid high in reset")

endmodule

bind dns_name_label_encoder dnle_checker u_chk (.*);
